/* hdl/sics_pkg.sv */
// ----------------------------------------------------------------------------
// sics_pkg: shared types and constants
// Payload structs, register indexes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package sics_pkg;

  localparam int CAPTURE_DEPTH_DEF = 256;
  localparam int SPREAD_LIMIT_DEF  = 128;
  localparam int SINE_ENTRIES      = 512;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TEST_FREQ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FREQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LIMIT = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] inject;
    logic               capture_valid;
    logic [7:0]         capture_index;
    logic [15:0]        capture_value;
    logic               running;
    logic               finished;
  } out_item_t;

  function automatic logic [14:0] quarter_sine(input logic [7:0] q);
    logic [14:0] v;
    unique case (q)
      8'd0: v = 15'd0;       8'd1: v = 15'd201;     8'd2: v = 15'd402;
      8'd3: v = 15'd603;     8'd4: v = 15'd804;     8'd5: v = 15'd1005;
      8'd6: v = 15'd1205;    8'd7: v = 15'd1406;    8'd8: v = 15'd1606;
      8'd9: v = 15'd1806;    8'd10: v = 15'd2006;   8'd11: v = 15'd2205;
      8'd12: v = 15'd2404;   8'd13: v = 15'd2603;   8'd14: v = 15'd2801;
      8'd15: v = 15'd2999;   8'd16: v = 15'd3196;   8'd17: v = 15'd3393;
      8'd18: v = 15'd3590;   8'd19: v = 15'd3786;   8'd20: v = 15'd3981;
      8'd21: v = 15'd4176;   8'd22: v = 15'd4370;   8'd23: v = 15'd4563;
      8'd24: v = 15'd4756;   8'd25: v = 15'd4948;   8'd26: v = 15'd5139;
      8'd27: v = 15'd5330;   8'd28: v = 15'd5520;   8'd29: v = 15'd5708;
      8'd30: v = 15'd5897;   8'd31: v = 15'd6084;   8'd32: v = 15'd6270;
      8'd33: v = 15'd6455;   8'd34: v = 15'd6639;   8'd35: v = 15'd6823;
      8'd36: v = 15'd7005;   8'd37: v = 15'd7186;   8'd38: v = 15'd7366;
      8'd39: v = 15'd7545;   8'd40: v = 15'd7723;   8'd41: v = 15'd7900;
      8'd42: v = 15'd8076;   8'd43: v = 15'd8250;   8'd44: v = 15'd8423;
      8'd45: v = 15'd8595;   8'd46: v = 15'd8765;   8'd47: v = 15'd8935;
      8'd48: v = 15'd9102;   8'd49: v = 15'd9269;   8'd50: v = 15'd9434;
      8'd51: v = 15'd9598;   8'd52: v = 15'd9760;   8'd53: v = 15'd9921;
      8'd54: v = 15'd10080;  8'd55: v = 15'd10238;  8'd56: v = 15'd10394;
      8'd57: v = 15'd10549;  8'd58: v = 15'd10702;  8'd59: v = 15'd10853;
      8'd60: v = 15'd11003;  8'd61: v = 15'd11151;  8'd62: v = 15'd11297;
      8'd63: v = 15'd11442;  8'd64: v = 15'd11585;  8'd65: v = 15'd11727;
      8'd66: v = 15'd11866;  8'd67: v = 15'd12004;  8'd68: v = 15'd12140;
      8'd69: v = 15'd12274;  8'd70: v = 15'd12406;  8'd71: v = 15'd12537;
      8'd72: v = 15'd12665;  8'd73: v = 15'd12792;  8'd74: v = 15'd12916;
      8'd75: v = 15'd13039;  8'd76: v = 15'd13160;  8'd77: v = 15'd13279;
      8'd78: v = 15'd13395;  8'd79: v = 15'd13510;  8'd80: v = 15'd13623;
      8'd81: v = 15'd13733;  8'd82: v = 15'd13842;  8'd83: v = 15'd13949;
      8'd84: v = 15'd14053;  8'd85: v = 15'd14155;  8'd86: v = 15'd14256;
      8'd87: v = 15'd14354;  8'd88: v = 15'd14449;  8'd89: v = 15'd14543;
      8'd90: v = 15'd14635;  8'd91: v = 15'd14724;  8'd92: v = 15'd14811;
      8'd93: v = 15'd14896;  8'd94: v = 15'd14978;  8'd95: v = 15'd15059;
      8'd96: v = 15'd15137;  8'd97: v = 15'd15213;  8'd98: v = 15'd15286;
      8'd99: v = 15'd15357;  8'd100: v = 15'd15426; 8'd101: v = 15'd15493;
      8'd102: v = 15'd15557; 8'd103: v = 15'd15619; 8'd104: v = 15'd15679;
      8'd105: v = 15'd15736; 8'd106: v = 15'd15791; 8'd107: v = 15'd15843;
      8'd108: v = 15'd15893; 8'd109: v = 15'd15941; 8'd110: v = 15'd15986;
      8'd111: v = 15'd16029; 8'd112: v = 15'd16069; 8'd113: v = 15'd16107;
      8'd114: v = 15'd16143; 8'd115: v = 15'd16176; 8'd116: v = 15'd16207;
      8'd117: v = 15'd16235; 8'd118: v = 15'd16261; 8'd119: v = 15'd16284;
      8'd120: v = 15'd16305; 8'd121: v = 15'd16324; 8'd122: v = 15'd16340;
      8'd123: v = 15'd16353; 8'd124: v = 15'd16364; 8'd125: v = 15'd16373;
      8'd126: v = 15'd16379; 8'd127: v = 15'd16383; 8'd128: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/sics_inject.sv */
// ----------------------------------------------------------------------------
// sics_inject: injection value unit
// Given the phase index, looks up the sine and scales it by the amplitude,
// rounding toward minus infinity; result is registered.
// ----------------------------------------------------------------------------
module sics_inject (
  input  logic               clk,
  input  logic [8:0]         index,
  input  logic [9:0]         amplitude,
  output logic signed [15:0] inject
);

  logic [7:0]  q;
  logic [7:0]  q_fold;
  logic [14:0] mag;
  logic [24:0] prod;
  logic [15:0] scaled;

  always_comb begin
    q = index[7:0];
    q_fold = (q <= 8'd128) ? q : 8'(9'd256 - {1'b0, q});
    mag = sics_pkg::quarter_sine(q_fold);
    prod = 25'(mag) * 25'(amplitude);
    // Floor shift of a negative product is minus the ceiling of the magnitude.
    if (index[8]) begin
      scaled = -16'((prod + 25'd511) >> 9);
    end else begin
      scaled = 16'(prod >> 9);
    end
  end

  always_ff @(posedge clk) begin
    inject <= signed'(scaled);
  end

endmodule

/* hdl/sine_inject_capture_scheduler.sv */
// ----------------------------------------------------------------------------
// sine_inject_capture_scheduler: frequency-response sine injection and capture
// ----------------------------------------------------------------------------
// Each transfer steps through READ, MUL1, MUL2, DEC, LUT and DONE from
// acceptance to result valid: the scan counters live in a one-entry state
// memory read, modified and written back by a small sequencer, and the
// phase product (32x25) and spread target product (16x32) are formed in a
// cycle of their own. One item is in flight at a time. The output
// register lets the next item be accepted while a result still waits; the
// sequencer then holds in its last step until the output register is free.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sine_inject_capture_scheduler #(
  parameter int CAPTURE_DEPTH = sics_pkg::CAPTURE_DEPTH_DEF,
  parameter int SPREAD_LIMIT  = sics_pkg::SPREAD_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sics_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sics_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sics_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sics_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_DEC  = 7'b0010000,
    S_LUT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [31:0] tick;
    logic [15:0] count;
    logic        active;
    logic        done;
  } scan_t;

  logic [15:0] test_freq, sample_freq;
  logic [9:0]  amplitude;
  logic [31:0] settle_ticks;
  logic [24:0] phase_step;
  logic [8:0]  capture_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_freq <= '0;
      sample_freq <= 16'd10204;
      amplitude <= '0;
      settle_ticks <= '0;
      phase_step <= '0;
      capture_limit <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sics_pkg::REG_TEST_FREQ:     test_freq <= cfg_data[15:0];
        sics_pkg::REG_SAMPLE_FREQ:   sample_freq <= cfg_data[15:0];
        sics_pkg::REG_AMPLITUDE:     amplitude <= cfg_data[9:0];
        sics_pkg::REG_SETTLE_TICKS:  settle_ticks <= cfg_data;
        sics_pkg::REG_PHASE_STEP:    phase_step <= cfg_data[24:0];
        sics_pkg::REG_CAPTURE_LIMIT: capture_limit <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // One-entry state memory; the init flag stands for its reset value.
  scan_t state_mem [1];
  scan_t rd;
  scan_t wr_data;
  logic  wr_en;
  logic  mem_init;

  always_ff @(posedge clk) begin
    if (wr_en) state_mem[0] <= wr_data;
    rd <= state_mem[0];
  end

  always_ff @(posedge clk) begin
    if (rst) mem_init <= 1'b0;
    else if (wr_en) mem_init <= 1'b1;
  end

  state_t state;
  sics_pkg::in_item_t item;
  scan_t cur;
  logic [56:0] ph_prod;
  logic [47:0] sp_prod;
  logic [40:0] target;
  logic        in_band;
  logic        tick_path;
  logic        cap_hit;
  logic        cap_ok;
  logic        end_scan;
  logic        done_go;
  logic [8:0]  ph_index;
  logic signed [15:0] inject_val;
  logic [31:0] half;
  logic [15:0] bound;

  assign half = {1'b0, settle_ticks[31:1]};
  assign bound = 16'((18'(sample_freq) * 18'd3) >> 7);
  assign in_ready = (state == S_IDLE);
  assign done_go = !out_valid || out_ready;

  sics_inject u_inject (
    .clk(clk),
    .index(ph_index),
    .amplitude(amplitude),
    .inject(inject_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_READ;
        S_READ: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_DEC;
        S_DEC:  state <= S_LUT;
        S_LUT:  state <= S_DONE;
        S_DONE: begin
          if (done_go) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready) item <= in_data;
    if (state == S_MUL1) begin
      cur <= mem_init ? rd : '0;
    end
    if (state == S_MUL2) begin
      ph_prod <= 57'(cur.tick) * 57'(phase_step);
      sp_prod <= 48'(cur.count) * 48'(settle_ticks);
      in_band <= (test_freq > bound) && (19'(test_freq) <= (19'(bound) << 3));
    end
    if (state == S_DEC) begin
      ph_index <= ph_prod[24:16];
      if (in_band) target <= 41'(half) + 41'(cur.count);
      else target <= 41'(half) + 41'(sp_prod[47:8]) + 41'(sp_prod[7:0] > 8'h80);
    end
    if (state == S_DONE && done_go) begin
      out_data.inject <= tick_path ? inject_val : '0;
      out_data.capture_valid <= cap_ok;
      out_data.capture_index <= cap_ok ? cur.count[7:0] : '0;
      out_data.capture_value <= cap_ok ? item.sample : '0;
      out_data.running <= wr_data.active;
      out_data.finished <= wr_data.done;
    end
  end

  always_comb begin
    end_scan = cur.tick == settle_ticks;
    tick_path = !item.mode && cur.active && (test_freq != 16'd0) && !end_scan;
    cap_hit = tick_path && (cur.tick >= half) && (41'(cur.tick) == target);
    if (in_band) begin
      cap_ok = cap_hit && (17'(cur.count) < 17'(capture_limit))
               && (32'(cur.count) < 32'(CAPTURE_DEPTH));
    end else begin
      cap_ok = cap_hit && (32'(cur.count) < 32'(SPREAD_LIMIT))
               && (32'(cur.count) < 32'(CAPTURE_DEPTH));
    end
    wr_data = cur;
    priority if (item.mode) begin
      wr_data = '{tick: '0, count: '0, active: 1'b1, done: 1'b0};
    end else if (!cur.active || test_freq == 16'd0) begin
      wr_data.tick = '0;
      wr_data.count = '0;
      wr_data.active = 1'b0;
    end else if (end_scan) begin
      wr_data = '{tick: '0, count: '0, active: 1'b0, done: 1'b1};
    end else begin
      wr_data.tick = cur.tick + 32'd1;
      if (cap_hit) wr_data.count = cur.count + 16'd1;
    end
    wr_en = (state == S_DONE) && done_go;
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result lost");
  a_capture_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.capture_valid) |-> (out_data.capture_index == 8'd0))
    else $error("capture index set without capture");

endmodule
